// ----- sv/wspl_pkg.sv -----
// shared constants, phase type and level function of the wav stream parser
`timescale 1ns / 1ps
`default_nettype none

package wspl_pkg;

	localparam int BLOCK_BYTES = 1024;
	localparam int BLK_W       = $clog2(BLOCK_BYTES);

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [15:0] FMT_PCM      = 16'd1;
	localparam logic [15:0] CH_STEREO    = 16'd2;
	localparam logic [15:0] BITS_SAMPLE  = 16'd16;
	localparam logic [16:0] LEVEL_CLAMP  = 17'd8000;
	localparam logic [16:0] LEVEL_FLOOR  = 17'd100;
	localparam logic [7:0]  DIV5_RECIP   = 8'd205;

	// header byte positions
	localparam logic [5:0] POS_RIFF_END  = 6'd3;
	localparam logic [5:0] POS_WAVE_END  = 6'd11;
	localparam logic [5:0] POS_FMT_END   = 6'd15;
	localparam logic [5:0] POS_TAG_END   = 6'd21;
	localparam logic [5:0] POS_CH_END    = 6'd23;
	localparam logic [5:0] POS_RATE_END  = 6'd27;
	localparam logic [5:0] POS_HDR_END   = 6'd35;
	localparam logic [5:0] POS_CTAG_END  = 6'd3;
	localparam logic [5:0] POS_CSIZE_END = 6'd7;

	localparam logic [2:0] EV_HEADER = 3'd0;
	localparam logic [2:0] EV_ACCEPT = 3'd1;
	localparam logic [2:0] EV_REJECT = 3'd2;
	localparam logic [2:0] EV_SKIP   = 3'd3;
	localparam logic [2:0] EV_DATA   = 3'd4;
	localparam logic [2:0] EV_IGNORE = 3'd5;

	localparam logic REG_RATE_Q8 = 1'b0;
	localparam logic [11:0] RATE_Q8_RESET = 12'd256;

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_CHUNK  = 5'b00010,
		PH_SKIP   = 5'b00100,
		PH_DATA   = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	// 0..100 level from one little-endian 16-bit sample
	function automatic logic [6:0] level_of(input logic [7:0] lo, input logic [7:0] hi);
		logic [15:0] raw;
		logic [16:0] mag;
		logic [8:0]  q16;
		logic [16:0] prod;
		begin
			raw = {hi, lo};
			mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
			if (mag > LEVEL_CLAMP) begin
				mag = LEVEL_CLAMP;
			end
			if (mag < LEVEL_FLOOR) begin
				mag = '0;
			end
			// divide by 80: shift right by 4 for the divide by 16, then times 205 over 1024 for the divide by 5
			q16  = mag[12:4];
			prod = {8'd0, q16} * {9'd0, DIV5_RECIP};
			level_of = prod[16:10];
		end
	endfunction

endpackage

`default_nettype wire

// ----- sv/wav_stream_parser_level_meter.sv -----
// top level: byte-wise wav header parser, data pass-through and level meter
//
// usage: one byte of a wav file per input request on the s_ channel, s_tdata
// holding the byte and s_tuser flagging the first byte of a new file. every
// byte yields exactly one result request on the m_ channel: m_tuser gives the
// event, m_tdata the passed data byte, data end flag, level, playback rate and
// stereo flag, m_tlast marks the last data byte of a block.
// playback_rate_q8 is written over the apb port at address 0.
// throughput: one byte per clock while m_tready is high; every byte passes an input register, one
// level of parse logic with a 32x12 rate multiply and a result register.
// stall: while m_tready is low the result holds and the input register still
// takes one more byte; s_tready drops only when both registers are full.
// reset: parse state returns to the start of the fixed header, level and
// sample rate clear, playback_rate_q8 returns to 256 (unity).
`timescale 1ns / 1ps
`default_nettype none

module wav_stream_parser_level_meter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// apb configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// byte input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // byte_value
	input  wire logic        s_tuser,  // start_of_file
	// result output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [55:0] m_tdata,  // data_byte, data_end, level, playback_rate, stereo, zeros
	output logic      [2:0]  m_tuser,  // event_res
	output logic             m_tlast   // block_end
);
	import wspl_pkg::*;

	logic [11:0] rate_q8_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       sof_s1;

	// result register
	logic        valid_s2;
	logic [2:0]  ev_s2;
	logic [7:0]  dbyte_s2;
	logic        bend_s2;
	logic        dend_s2;
	logic [6:0]  lvl_s2;
	logic [31:0] rate_s2;
	logic        stereo_s2;

	// parse state
	phase_t           phase_q;
	logic [5:0]       pos_q;
	logic [31:0]      tag_q;
	logic [31:0]      fld_q;
	logic [31:0]      remain_q;
	logic [BLK_W-1:0] blk_q;
	logic             hok_q;
	logic [31:0]      srate_q;
	logic             st_q;
	logic [7:0]       flb_q;
	logic [6:0]       lvl_q;
	logic             pad_q;

	// next state
	phase_t           phase_d;
	logic [5:0]       pos_d;
	logic [31:0]      tag_d;
	logic [31:0]      fld_d;
	logic [31:0]      remain_d;
	logic [BLK_W-1:0] blk_d;
	logic             hok_d;
	logic [31:0]      srate_d;
	logic             st_d;
	logic [7:0]       flb_d;
	logic [6:0]       lvl_d;
	logic             pad_d;

	logic [2:0]  ev;
	logic [7:0]  dbyte;
	logic        bend;
	logic        dend;
	logic [6:0]  lvl_out;
	logic        accepted;
	logic [43:0] rate_prod;
	logic [31:0] rate_sat;

	logic advance;
	logic cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_RATE_Q8);
	assign prdata   = (paddr[2] == REG_RATE_Q8) ? {20'd0, rate_q8_q} : 32'd0;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = valid_s2;
	assign m_tuser  = ev_s2;
	assign m_tlast  = bend_s2;
	assign m_tdata  = {7'd0, stereo_s2, rate_s2, lvl_s2, dend_s2, dbyte_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q8_q <= RATE_Q8_RESET;
		end else if (cfg_wr) begin
			rate_q8_q <= pwdata[11:0];
		end
	end

	// rate from the stored sample rate; it is final well before the header is accepted
	assign rate_prod = {12'd0, srate_q} * {32'd0, rate_q8_q};
	assign rate_sat  = (|rate_prod[43:40]) ? 32'hFFFF_FFFF : rate_prod[39:8];

	always_comb begin
		logic [7:0]  b;
		phase_t      ph;
		logic [5:0]  pos;
		logic [31:0] remain;
		logic [BLK_W-1:0] blk;
		logic        hok;
		logic [31:0] srate;
		logic        st;
		logic [7:0]  flb;
		logic [6:0]  lvl;
		logic        pad;
		logic [31:0] tag;
		logic [31:0] fld;

		b = byte_s1;
		if (sof_s1) begin
			ph     = PH_HEADER;
			pos    = '0;
			tag    = '0;
			fld    = '0;
			remain = '0;
			blk    = '0;
			hok    = 1'b1;
			srate  = '0;
			st     = 1'b0;
			flb    = '0;
			lvl    = '0;
			pad    = 1'b0;
		end else begin
			ph     = phase_q;
			pos    = pos_q;
			tag    = tag_q;
			fld    = fld_q;
			remain = remain_q;
			blk    = blk_q;
			hok    = hok_q;
			srate  = srate_q;
			st     = st_q;
			flb    = flb_q;
			lvl    = lvl_q;
			pad    = pad_q;
		end

		tag_d    = {tag[23:0], b};
		fld_d    = {b, fld[31:8]};
		phase_d  = ph;
		pos_d    = pos;
		remain_d = remain;
		blk_d    = blk;
		hok_d    = hok;
		srate_d  = srate;
		st_d     = st;
		flb_d    = flb;
		lvl_d    = lvl;
		pad_d    = pad;
		ev       = EV_IGNORE;
		dbyte    = '0;
		bend     = 1'b0;
		dend     = 1'b0;

		unique case (ph)
			PH_HEADER: begin
				ev = EV_HEADER;
				if (pos == POS_RIFF_END && tag_d != TAG_RIFF) begin
					hok_d = 1'b0;
				end
				if (pos == POS_WAVE_END && tag_d != TAG_WAVE) begin
					hok_d = 1'b0;
				end
				if (pos == POS_FMT_END && tag_d != TAG_FMT) begin
					hok_d = 1'b0;
				end
				if (pos == POS_TAG_END && fld_d[31:16] != FMT_PCM) begin
					hok_d = 1'b0;
				end
				if (pos == POS_CH_END) begin
					if (fld_d[31:16] == 16'd0 || fld_d[31:16] > CH_STEREO) begin
						hok_d = 1'b0;
					end
					st_d = (fld_d[31:16] == CH_STEREO);
				end
				if (pos == POS_RATE_END) begin
					srate_d = fld_d;
				end
				pos_d = pos + 6'd1;
				if (pos == POS_HDR_END) begin
					if (fld_d[31:16] != BITS_SAMPLE) begin
						hok_d = 1'b0;
					end
					if (hok_d) begin
						ev      = EV_ACCEPT;
						phase_d = PH_CHUNK;
						pos_d   = '0;
					end else begin
						ev      = EV_REJECT;
						phase_d = PH_DONE;
					end
				end
			end
			PH_CHUNK: begin
				ev = EV_HEADER;
				if (pos == POS_CTAG_END) begin
					flb_d = '0;
					pad_d = (tag_d == TAG_DATA);
				end
				if (pos == POS_CSIZE_END) begin
					remain_d = fld_d;
					pos_d    = '0;
					if (pad) begin
						pad_d = 1'b0;
						blk_d = '0;
						if (fld_d == 32'd0) begin
							dend    = 1'b1;
							phase_d = PH_DONE;
						end else begin
							phase_d = PH_DATA;
						end
					end else begin
						pad_d = fld_d[0];
						if (fld_d != 32'd0) begin
							phase_d = PH_SKIP;
						end
					end
				end else begin
					pos_d = pos + 6'd1;
				end
			end
			PH_SKIP: begin
				ev = EV_SKIP;
				if (remain != 32'd0) begin
					remain_d = remain - 32'd1;
				end else begin
					pad_d = 1'b0;
				end
				if (remain_d == 32'd0 && !pad_d) begin
					phase_d = PH_CHUNK;
					pos_d   = '0;
				end
			end
			PH_DATA: begin
				ev       = EV_DATA;
				dbyte    = b;
				remain_d = remain - 32'd1;
				if (blk == '0) begin
					flb_d = b;
					if (remain_d == 32'd0) begin
						lvl_d = level_of(b, 8'd0);
					end
				end else if (blk == BLK_W'(1)) begin
					lvl_d = level_of(flb, b);
				end
				blk_d = blk + BLK_W'(1);
				if (blk == BLK_W'(BLOCK_BYTES - 1) || remain_d == 32'd0) begin
					bend  = 1'b1;
					blk_d = '0;
				end
				if (remain_d == 32'd0) begin
					dend    = 1'b1;
					phase_d = PH_DONE;
				end
			end
			PH_DONE: begin
				ev = EV_IGNORE;
			end
			default: begin
				ev = EV_IGNORE;
			end
		endcase

		lvl_out = lvl_d;
		if (dend && ev == EV_DATA) begin
			lvl_d = '0;
		end
		accepted = hok_d && (phase_d != PH_HEADER);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			sof_s1  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			ev_s2     <= ev;
			dbyte_s2  <= dbyte;
			bend_s2   <= bend;
			dend_s2   <= dend;
			lvl_s2    <= lvl_out;
			rate_s2   <= accepted ? rate_sat : 32'd0;
			stereo_s2 <= accepted && st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			tag_q    <= '0;
			fld_q    <= '0;
			remain_q <= '0;
			blk_q    <= '0;
			hok_q    <= 1'b1;
			srate_q  <= '0;
			st_q     <= 1'b0;
			flb_q    <= '0;
			lvl_q    <= '0;
			pad_q    <= 1'b0;
		end else if (advance && valid_s1) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			tag_q    <= tag_d;
			fld_q    <= fld_d;
			remain_q <= remain_d;
			blk_q    <= blk_d;
			hok_q    <= hok_d;
			srate_q  <= srate_d;
			st_q     <= st_d;
			flb_q    <= flb_d;
			lvl_q    <= lvl_d;
			pad_q    <= pad_d;
		end
	end

endmodule

`default_nettype wire

// ----- tb/sv/tb_wav_stream_parser_level_meter.sv -----
// testbench: wav byte stream parser and level meter, checked result by result against a parser model
`timescale 1ns / 1ps

module tb_wav_stream_parser_level_meter;
	import wspl_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int LEVEL_SPAN     = 100;
	localparam logic [2:0] ADDR_RATE_Q8 = {REG_RATE_Q8, 2'b00};

	typedef struct packed {
		logic [2:0]  ev_code;
		logic [7:0]  byte_out;
		logic        blk_last;
		logic        dat_last;
		logic [6:0]  level;
		logic [31:0] rate;
		logic        stereo;
	} meter_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;  // byte_value
	logic        s_tuser = 1'b0;  // start_of_file
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;  // data_byte, data_end, level, playback_rate, stereo, zeros
	logic [2:0]  m_tuser;  // event_res
	logic        m_tlast;  // block_end

	wav_stream_parser_level_meter u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// parser model state
	phase_t      cur_phase;
	logic [31:0] pos, tag_sr, field_sr, remaining, srate;
	int          blk_pos;
	logic        hdr_ok, stereo_f, is_data_chunk, pad;
	logic [7:0]  first_lo;
	logic [6:0]  lvl;
	logic [11:0] rate_q8;

	meter_result_t expected_results[$];
	logic [7:0]    file_bytes[$];
	int            errors = 0;
	int            sent_count = 0;
	int            idle_cycles = 0;
	bit            tx_quiet = 1'b0;
	bit            hold_req = 1'b0;

	task automatic restart_parser();
		cur_phase     = PH_HEADER;
		pos           = '0;
		tag_sr        = '0;
		field_sr      = '0;
		remaining     = '0;
		blk_pos       = 0;
		hdr_ok        = 1'b1;
		srate         = '0;
		stereo_f      = 1'b0;
		is_data_chunk = 1'b0;
		pad           = 1'b0;
		first_lo      = '0;
		lvl           = '0;
	endtask

	function automatic logic [6:0] sample_level(input logic [7:0] lo, input logic [7:0] hi);
		logic [15:0] raw;
		int          mag;
		raw = {hi, lo};
		mag = raw[15] ? 65536 - int'(raw) : int'(raw);
		if (mag > int'(LEVEL_CLAMP)) begin
			mag = int'(LEVEL_CLAMP);
		end
		if (mag < int'(LEVEL_FLOOR)) begin
			mag = 0;
		end
		return 7'(mag * LEVEL_SPAN / int'(LEVEL_CLAMP));
	endfunction

	task automatic advance_parser(input logic [7:0] b, input logic sof, output meter_result_t r);
		logic [63:0] prod;
		logic        accepted;
		r = '0;
		r.ev_code = EV_IGNORE;
		if (sof) begin
			restart_parser();
		end
		tag_sr   = {tag_sr[23:0], b};
		field_sr = {b, field_sr[31:8]};
		case (cur_phase)
			PH_HEADER: begin
				r.ev_code = EV_HEADER;
				case (pos)
					POS_RIFF_END: if (tag_sr != TAG_RIFF) hdr_ok = 1'b0;
					POS_WAVE_END: if (tag_sr != TAG_WAVE) hdr_ok = 1'b0;
					POS_FMT_END:  if (tag_sr != TAG_FMT) hdr_ok = 1'b0;
					POS_TAG_END:  if (field_sr[31:16] != FMT_PCM) hdr_ok = 1'b0;
					POS_CH_END: begin
						if (field_sr[31:16] == 16'd0 || field_sr[31:16] > CH_STEREO) begin
							hdr_ok = 1'b0;
						end
						stereo_f = (field_sr[31:16] == CH_STEREO);
					end
					POS_RATE_END: srate = field_sr;
					POS_HDR_END: begin
						if (field_sr[31:16] != BITS_SAMPLE) begin
							hdr_ok = 1'b0;
						end
						r.ev_code = hdr_ok ? EV_ACCEPT : EV_REJECT;
						cur_phase = hdr_ok ? PH_CHUNK : PH_DONE;
					end
					default: ;
				endcase
				pos++;
				if (cur_phase == PH_CHUNK) begin
					pos = '0;
				end
			end
			PH_CHUNK: begin
				r.ev_code = EV_HEADER;
				if (pos == POS_CTAG_END) begin
					first_lo      = '0;
					is_data_chunk = (tag_sr == TAG_DATA);
				end
				if (pos == POS_CSIZE_END) begin
					remaining = field_sr;
					pos       = '0;
					if (is_data_chunk) begin
						blk_pos = 0;
						if (remaining == 0) begin
							r.dat_last = 1'b1;
							cur_phase  = PH_DONE;
						end else begin
							cur_phase = PH_DATA;
						end
					end else begin
						pad = remaining[0];
						if (remaining != 0 || pad) begin
							cur_phase = PH_SKIP;
						end
					end
				end else begin
					pos++;
				end
			end
			PH_SKIP: begin
				r.ev_code = EV_SKIP;
				if (remaining != 0) begin
					remaining--;
				end else begin
					pad = 1'b0;
				end
				if (remaining == 0 && !pad) begin
					cur_phase = PH_CHUNK;
					pos       = '0;
				end
			end
			PH_DATA: begin
				r.ev_code  = EV_DATA;
				r.byte_out = b;
				remaining--;
				if (blk_pos == 0) begin
					first_lo = b;
					if (remaining == 0) begin
						lvl = sample_level(b, 8'd0);
					end
				end else if (blk_pos == 1) begin
					lvl = sample_level(first_lo, b);
				end
				blk_pos++;
				if (blk_pos >= BLOCK_BYTES || remaining == 0) begin
					r.blk_last = 1'b1;
					blk_pos    = 0;
				end
				if (remaining == 0) begin
					r.dat_last = 1'b1;
					cur_phase  = PH_DONE;
				end
			end
			default: r.ev_code = EV_IGNORE;
		endcase
		r.level = lvl;
		if (r.dat_last && r.ev_code == EV_DATA) begin
			lvl = '0;
		end
		accepted = hdr_ok && (cur_phase != PH_HEADER);
		prod = ({32'd0, srate} * {52'd0, rate_q8}) >> 8;
		if (prod > 64'hFFFF_FFFF) begin
			prod = 64'hFFFF_FFFF;
		end
		r.rate   = accepted ? prod[31:0] : 32'd0;
		r.stereo = accepted && stereo_f;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : monitor
		meter_result_t predicted, got, want;
		if (s_tvalid && s_tready) begin
			advance_parser(s_tdata, s_tuser, predicted);
			expected_results.insert(expected_results.size(), predicted);
		end
		if (m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[7:0], m_tlast, m_tdata[8], m_tdata[15:9],
				m_tdata[47:16], m_tdata[48]};
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: expected none actual %0h", $time, got);
				errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("event", 32'(want.ev_code), 32'(got.ev_code));
				check_field("data_byte", 32'(want.byte_out), 32'(got.byte_out));
				check_field("block_end", 32'(want.blk_last), 32'(got.blk_last));
				check_field("data_end", 32'(want.dat_last), 32'(got.dat_last));
				check_field("level", 32'(want.level), 32'(got.level));
				check_field("playback_rate", want.rate, got.rate);
				check_field("stereo", 32'(want.stereo), 32'(got.stereo));
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	initial begin : receiver
		int stall_left, mode_left;
		bit quiet;
		stall_left = 0;
		mode_left  = 0;
		quiet      = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					quiet     = ($urandom_range(0, 3) == 0);
					mode_left = $urandom_range(50, 300);
				end else begin
					mode_left--;
				end
				if (stall_left > 0) begin
					m_tready <= 1'b0;
					stall_left--;
				end else begin
					m_tready <= 1'b1;
					stall_left = pick_gap(quiet);
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic sof);
		int gap;
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= sof;
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	task automatic add_byte(input logic [7:0] v);
		file_bytes.insert(file_bytes.size(), v);
	endtask

	task automatic put_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++) begin
			add_byte(v[8*i +: 8]);
		end
	endtask

	task automatic put_tag(input logic [31:0] t);
		for (int i = 3; i >= 0; i--) begin
			add_byte(t[8*i +: 8]);
		end
	endtask

	// cut: 0 sends the whole file, >0 at most that many bytes, <0 a random prefix
	task automatic send_file(input logic [15:0] fmt, input logic [15:0] chans,
		input logic [15:0] bits, input logic [31:0] rate_hz, input int bad_tag,
		input int n_skip, input int n_data, input logic [15:0] sample,
		input int trailer, input int cut);
		logic [31:0] flip, tag, size;
		int          n;
		file_bytes.delete();
		flip = 32'd1 << $urandom_range(0, 31);
		put_tag(TAG_RIFF ^ (bad_tag == 1 ? flip : 32'd0));
		put_le($urandom, 4);
		put_tag(TAG_WAVE ^ (bad_tag == 2 ? flip : 32'd0));
		put_tag(TAG_FMT ^ (bad_tag == 3 ? flip : 32'd0));
		put_le(32'd16, 4);
		put_le(32'(fmt), 2);
		put_le(32'(chans), 2);
		put_le(rate_hz, 4);
		put_le($urandom, 4);
		put_le($urandom, 2);
		put_le(32'(bits), 2);
		repeat (n_skip) begin
			tag = $urandom;
			if (tag == TAG_DATA) begin
				tag ^= 32'd1;
			end
			size = $urandom_range(0, 9);
			put_tag(tag);
			put_le(size, 4);
			repeat (size + size[0]) add_byte(8'($urandom));
		end
		if (n_data >= 0) begin
			put_tag(TAG_DATA);
			put_le(32'(n_data), 4);
			for (int i = 0; i < n_data; i++) begin
				add_byte(i == 0 ? sample[7:0] : i == 1 ? sample[15:8] : 8'($urandom));
			end
		end
		repeat (trailer) add_byte(8'($urandom));
		n = file_bytes.size();
		if (cut > 0 && cut < n) begin
			n = cut;
		end else if (cut < 0) begin
			n = $urandom_range(1, n);
		end
		tx_quiet = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++) begin
			send_byte(file_bytes[i], i == 0);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_accept_stereo();
		send_file(FMT_PCM, CH_STEREO, BITS_SAMPLE, 32'hFFFF_FFFF, 0, 2, 4, 16'h8000, 2, 0);
	endtask

	task automatic test_reject_header();
		send_file(FMT_PCM, 16'd3, BITS_SAMPLE, 32'd44100, 0, 0, 4, 16'd0, 3, 0);
	endtask

	task automatic test_empty_data();
		send_file(FMT_PCM, 16'd1, BITS_SAMPLE, 32'd8000, 0, 0, 0, 16'd0, 2, 0);
	endtask

	task automatic test_lone_byte();
		send_file(FMT_PCM, 16'd1, BITS_SAMPLE, 32'd48000, 0, 0, 1, 16'h00FF, 1, 0);
	endtask

	task automatic test_restart_mid_file();
		send_file(FMT_PCM, CH_STEREO, BITS_SAMPLE, 32'd22050, 0, 0, 6, 16'h7FFF, 0, 20);
		send_file(FMT_PCM, 16'd1, BITS_SAMPLE, 32'd22050, 0, 0, 3, 16'hE0C0, 0, 0);
	endtask

	task automatic test_rate_setting(input logic [11:0] value);
		wait_idle();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_RATE_Q8;
		pwdata  <= {20'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rate_q8 = value;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {20'd0, value}) begin
			$display("%0t playback_rate_q8 readback: expected %0h actual %0h",
				$time, {20'd0, value}, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// long data chunk crosses a block boundary while the receiver holds off
	task automatic test_backpressure();
		hold_req = 1'b1;
		send_file(FMT_PCM, CH_STEREO, BITS_SAMPLE, 32'd44100, 0, 1, BLOCK_BYTES + 1,
			16'h1F40, 0, 0);
	endtask

	task automatic test_random_files(input int n_items);
		logic [15:0] levels[15] = '{16'd0, 16'd99, 16'd100, 16'd101, 16'd7999, 16'd8000,
			16'd8001, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFF9C, 16'hFF9D, 16'hE0C0,
			16'd180, 16'd80};
		logic [15:0] fmt, chans, bits, sample;
		logic [31:0] rate_hz;
		int          start, r, n_data;
		start = sent_count;
		while (sent_count - start < n_items) begin
			fmt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : FMT_PCM;
			r = $urandom_range(0, 99);
			chans = r < 45 ? 16'd1 : r < 90 ? CH_STEREO : r < 94 ? 16'd0 :
				r < 97 ? 16'd3 : 16'($urandom);
			bits = ($urandom_range(0, 9) == 0) ? 16'($urandom) : BITS_SAMPLE;
			case ($urandom_range(0, 5))
				0: rate_hz = 32'd8000;
				1: rate_hz = 32'd44100;
				2: rate_hz = 32'd48000;
				3: rate_hz = 32'd0;
				4: rate_hz = 32'hFFFF_FFFF;
				default: rate_hz = $urandom;
			endcase
			r = $urandom_range(0, 99);
			n_data = r < 5 ? -1 : r < 12 ? 0 : r < 20 ? 1 : $urandom_range(2, 24);
			sample = ($urandom_range(0, 1) == 0) ? levels[$urandom_range(0, 14)] :
				16'($urandom);
			send_file(fmt, chans, bits, rate_hz,
				($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0,
				$urandom_range(0, 2), n_data, sample, $urandom_range(0, 3),
				($urandom_range(0, 9) == 0) ? -1 : 0);
		end
	endtask

	task automatic test_noise(input int n_items);
		tx_quiet = 1'b0;
		repeat (n_items) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
	endtask

	initial begin
		restart_parser();
		rate_q8 = RATE_Q8_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_accept_stereo();
		test_reject_header();
		test_empty_data();
		test_lone_byte();
		test_restart_mid_file();

		test_rate_setting(12'd0);
		test_random_files(30);
		test_rate_setting(12'd4095);
		test_backpressure();
		test_random_files(30);
		test_rate_setting(12'($urandom));
		test_random_files(30);
		test_rate_setting(RATE_Q8_RESET);
		test_random_files(30);
		test_noise(60);

		wait_idle();
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
